// File: rtl/lfff_pkg.sv
// Package for the length-prefixed frame filter: sizes, frame constants and FSM type.
`timescale 1ns / 1ps
package lfff_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = 16;

    localparam logic [LEN_W-1:0] HB_LENGTH      = 16'd22;
    localparam logic [7:0]       HB_TAG         = 8'hA0;
    localparam logic [LEN_W-1:0] UPD_LENGTH     = 16'd49;
    localparam logic [7:0]       UPD_TAG        = 8'h21;
    localparam logic [CNT_W-1:0] LEN_HI_POS     = CNT_W'(1);
    localparam logic [CNT_W-1:0] LEN_LO_POS     = CNT_W'(2);
    localparam logic [CNT_W-1:0] TAG_POS        = CNT_W'(16);
    localparam logic [CNT_W-1:0] UPD_ID_POS     = CNT_W'(26);
    localparam logic [CNT_W-1:0] UPD_FIRST      = CNT_W'(37);
    localparam logic [CNT_W-1:0] UPD_LAST       = CNT_W'(40);
    localparam logic [CNT_W-1:0] FWD_FIRST      = CNT_W'(15);
    localparam logic [LEN_W:0]   FRAME_OVERHEAD = 17'd4;
    // shortest length that forwards at least one word
    localparam logic [LEN_W-1:0] FWD_MIN_LENGTH = 16'd13;
    localparam logic [CNT_W-1:0] CNT_WRAP       = CNT_W'(BUFFER_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

endpackage

// File: rtl/length_frame_filter_forwarder.sv
// Top level: frame buffer memory, byte counter, length latch and drain sequencer.
//
//  channel | direction | handshake              | payload
//  rx      | in        | i_rx_valid / o_rx_stall | i_rx_byte[7:0]
//  tx      | out       | o_tx_valid / i_tx_stall | o_tx_byte[7:0], o_last_of_run
//
// An rx word that does not complete a frame is accepted without stalling rx. A completing
// word starts a drain through the buffer memory: a registered read, then one
// tx word per cycle while tx is not stalled (at most 47 words).
// rx is stalled for the whole drain; the final tx word may still wait while rx runs.
// Reset (synchronous, active low) clears counter, length, FSM and tx valid; the
// buffer contents are left as they are.
`timescale 1ns / 1ps
module length_frame_filter_forwarder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_tx_valid,
    input  logic       i_tx_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_of_run
);
    import lfff_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] r_mem_q;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_tx_byte, n_tx_byte;
    logic             r_last, n_last;
    logic [7:0]       r_hi, n_hi;
    logic [7:0]       r_tag, n_tag;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_last_addr, n_last_addr;
    logic             r_upd, n_upd;

    logic             w_accept;
    logic [CNT_W-1:0] w_rd_addr;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [LEN_W-1:0] w_len_now;
    logic [7:0]       w_tag_now;
    logic             w_done;
    logic             w_slot_free;
    logic             w_at_last;
    logic [CNT_W-1:0] w_next_addr;

    assign w_accept    = i_rx_valid && (r_state == ST_IDLE);
    assign w_cnt_inc   = r_count + CNT_W'(1);
    // byte 2 and byte 16 are used in the step that writes them
    assign w_len_now   = (r_count == LEN_LO_POS) ? {r_hi, i_rx_byte} : r_len;
    assign w_tag_now   = (r_count == TAG_POS) ? i_rx_byte : r_tag;
    assign w_done      = {(LEN_W + 1 - CNT_W)'(0), w_cnt_inc}
                         == ({1'b0, w_len_now} + FRAME_OVERHEAD);
    assign w_slot_free = !r_out_valid || !i_tx_stall;
    assign w_at_last   = (r_addr == r_last_addr);
    assign w_next_addr = (r_upd && r_addr == UPD_ID_POS) ? UPD_FIRST
                                                          : r_addr + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_hi        = r_hi;
        n_tag       = w_tag_now;
        n_addr      = r_addr;
        n_last_addr = r_last_addr;
        n_upd       = r_upd;
        n_out_valid = r_out_valid && i_tx_stall;
        n_tx_byte   = r_tx_byte;
        n_last      = r_last;
        w_rd_addr   = r_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (!w_accept) begin
                    n_tag = r_tag;
                end else begin
                    if (r_count == LEN_HI_POS) begin
                        n_hi = i_rx_byte;
                    end
                    n_len = w_len_now;
                    if (w_done) begin
                        n_count = '0;
                        if (w_len_now == HB_LENGTH && w_tag_now == HB_TAG) begin
                            n_len = '0;
                        end else if (w_len_now == UPD_LENGTH && w_tag_now == UPD_TAG) begin
                            n_addr      = UPD_ID_POS;
                            n_last_addr = UPD_LAST;
                            n_upd       = 1'b1;
                            n_state     = ST_READ;
                        end else if (w_len_now >= FWD_MIN_LENGTH) begin
                            n_addr      = FWD_FIRST;
                            n_last_addr = w_len_now[CNT_W-1:0] + CNT_W'(2);
                            n_upd       = 1'b0;
                            n_state     = ST_READ;
                        end
                    end else if (w_cnt_inc >= CNT_WRAP) begin
                        n_count = '0;
                    end else begin
                        n_count = w_cnt_inc;
                    end
                end
            end
            ST_READ: begin
                n_tag   = r_tag;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_tag = r_tag;
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_tx_byte   = r_mem_q;
                    n_last      = w_at_last;
                    if (w_at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // next read issued while this word loads
                        n_addr    = w_next_addr;
                        w_rd_addr = w_next_addr;
                    end
                end
            end
            default: begin
                n_tag   = r_tag;
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx_byte   <= n_tx_byte;
        r_last      <= n_last;
        r_hi        <= n_hi;
        r_tag       <= n_tag;
        r_addr      <= n_addr;
        r_last_addr <= n_last_addr;
        r_upd       <= n_upd;
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_count] <= i_rx_byte;
        end
        r_mem_q <= mem[w_rd_addr];
    end

    assign o_rx_stall    = (r_state != ST_IDLE);
    assign o_tx_valid    = r_out_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_last_of_run = r_last;

endmodule

// File: dv/tb.sv
// Self-checking bench for the frame filter: random framed byte stream in, drained words checked.
`timescale 1ns / 1ps
module tb;
    import lfff_pkg::*;

    localparam int MAX_FRAME_LEN = int'(CNT_WRAP) - int'(FRAME_OVERHEAD);
    localparam int STUCK_LIMIT   = 2000;
    localparam int DRAIN_WAIT    = 64;
    localparam int RANDOM_BYTES  = 16;
    localparam int CALM_MARK     = 80;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_tx_word;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte  = 8'd0;
    logic       i_tx_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_last_of_run;

    length_frame_filter_forwarder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_tx_valid    (o_tx_valid),
        .i_tx_stall    (i_tx_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // stimulus and expectations
    logic [7:0] rx_pending[$];
    t_tx_word   tx_expected[$];

    // shadow of the frame buffer, counter and length latch
    bit   [7:0]       frame_shadow [BUFFER_DEPTH];
    logic [CNT_W-1:0] count_shadow  = '0;
    logic [LEN_W-1:0] length_shadow = '0;

    int mismatches    = 0;
    int words_checked = 0;
    int frames_queued = 0;
    int heartbeats    = 0;
    int updates       = 0;
    int stuck_cycles  = 0;
    int rx_gap        = 0;
    int tx_gap        = 0;
    bit calm          = 1'b0;
    bit lull          = 1'b0;
    t_tx_word want;

    function automatic void deframe_byte(input logic [7:0] rx);
        logic [LEN_W:0] done_at;
        logic [7:0]     drained[$];
        drained = {};
        frame_shadow[count_shadow] = rx;
        if (count_shadow == LEN_LO_POS)
            length_shadow = {frame_shadow[LEN_HI_POS], frame_shadow[LEN_LO_POS]};
        count_shadow = count_shadow + 1'b1;
        done_at = {1'b0, length_shadow} + FRAME_OVERHEAD;
        if ({{(LEN_W + 1 - CNT_W){1'b0}}, count_shadow} == done_at) begin
            if (length_shadow == HB_LENGTH && frame_shadow[TAG_POS] == HB_TAG) begin
                // heartbeat: swallowed, length latch cleared too
                count_shadow  = '0;
                length_shadow = '0;
                return;
            end
            if (length_shadow == UPD_LENGTH && frame_shadow[TAG_POS] == UPD_TAG) begin
                drained.push_back(frame_shadow[UPD_ID_POS]);
                for (int i = int'(UPD_FIRST); i <= int'(UPD_LAST); i++)
                    drained.push_back(frame_shadow[i]);
            end else begin
                for (int i = int'(FWD_FIRST);
                     i < int'(length_shadow) + 3 && i < BUFFER_DEPTH; i++)
                    drained.push_back(frame_shadow[i]);
            end
            foreach (drained[k])
                tx_expected.push_back('{tx_byte: drained[k],
                                        last_of_run: (k == drained.size() - 1)});
            count_shadow = '0;
        end else if (count_shadow >= CNT_WRAP) begin
            count_shadow = '0;
        end
    endfunction

    // one frame as the length field says; lengths past the buffer get one wrap's worth
    task automatic queue_frame(input logic [15:0] len, input t_fill fill,
                               input bit set_tag, input logic [7:0] tag);
        logic [7:0] b;
        int total;
        total = (int'(len) <= MAX_FRAME_LEN) ? int'(len) + int'(FRAME_OVERHEAD)
                                             : int'(CNT_WRAP);
        for (int k = 0; k < total; k++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            if (k == int'(LEN_HI_POS))
                b = len[15:8];
            else if (k == int'(LEN_LO_POS))
                b = len[7:0];
            else if (set_tag && k == int'(TAG_POS))
                b = tag;
            rx_pending.push_back(b);
        end
        frames_queued++;
        if (set_tag && len == HB_LENGTH && tag == HB_TAG)
            heartbeats++;
        if (set_tag && len == UPD_LENGTH && tag == UPD_TAG)
            updates++;
    endtask

    // rx driver: predicts each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || !o_rx_stall) begin
            if (i_rx_valid)
                deframe_byte(i_rx_byte);
            if (rx_gap == 0 && !calm && !lull && $urandom_range(0, 11) == 0)
                rx_gap = $urandom_range(1, 17);
            if (rx_gap > 0) begin
                rx_gap--;
                i_rx_valid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= rx_pending.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // tx backpressure
    always @(posedge i_clk) begin
        if (tx_gap == 0 && !calm && !lull && $urandom_range(0, 7) == 0)
            tx_gap = $urandom_range(1, 17);
        if (tx_gap > 0) begin
            tx_gap--;
            i_tx_stall <= 1'b1;
        end else begin
            i_tx_stall <= 1'b0;
        end
    end

    // stretches without any idling
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0)
            lull <= !lull;
    end

    // tx monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_tx_valid && !i_tx_stall) begin
            if (tx_expected.size() == 0) begin
                $error("unexpected tx word: tx_byte=%02h last_of_run=%0b",
                       o_tx_byte, o_last_of_run);
                mismatches++;
            end else begin
                want = tx_expected.pop_front();
                if (o_tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, o_tx_byte);
                    mismatches++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, o_last_of_run);
                    mismatches++;
                end
                words_checked++;
            end
        end
        if (i_rst_n && ((o_tx_valid && !i_tx_stall) || (i_rx_valid && !o_rx_stall))) begin
            stuck_cycles = 0;
        end else if (rx_pending.size() > 0 || i_rx_valid || tx_expected.size() > 0) begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $error("no word moved for %0d cycles, %0d tx words outstanding",
                       STUCK_LIMIT, tx_expected.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int len;
        int random_start;

        // directed frames; the first one fills the tag position
        queue_frame(16'd13, FILL_RANDOM, 1'b0, 8'h00);
        queue_frame(16'(MAX_FRAME_LEN), FILL_ONES, 1'b0, 8'h00);
        queue_frame(16'd0, FILL_RANDOM, 1'b0, 8'h00);
        queue_frame(HB_LENGTH, FILL_RANDOM, 1'b1, HB_TAG);
        queue_frame(UPD_LENGTH, FILL_RANDOM, 1'b1, UPD_TAG);
        queue_frame(16'hFFFF, FILL_ONES, 1'b0, 8'h00);

        // random frames, mostly well formed
        random_start = rx_pending.size();
        while (rx_pending.size() - random_start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                len = $urandom_range(13, MAX_FRAME_LEN);
                queue_frame(16'(len), FILL_RANDOM, 1'b0, 8'h00);
            end else if (pick < 50) begin
                len = $urandom_range(0, int'(FWD_MIN_LENGTH) - 1);
                queue_frame(16'(len), FILL_RANDOM, 1'b0, 8'h00);
            end else if (pick < 62) begin
                queue_frame(HB_LENGTH, FILL_RANDOM, 1'b1, HB_TAG);
            end else if (pick < 74) begin
                queue_frame(UPD_LENGTH, FILL_RANDOM, 1'b1, UPD_TAG);
            end else if (pick < 82) begin
                // right length, random tag
                queue_frame($urandom_range(0, 1) ? HB_LENGTH : UPD_LENGTH, FILL_RANDOM,
                            1'b1, 8'($urandom_range(0, 255)));
            end else begin
                // length the counter never reaches: runs to the wrap
                len = $urandom_range(MAX_FRAME_LEN + 1, 65535);
                queue_frame(16'(len), FILL_RANDOM, 1'b0, 8'h00);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() > CALM_MARK)
            @(posedge i_clk);
        calm <= 1'b1;

        while (rx_pending.size() > 0 || i_rx_valid || tx_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d frames (%0d heartbeats, %0d update frames) with idle and stall bursts,",
                 frames_queued, heartbeats, updates);
        $display("checked %0d tx words.", words_checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
